// ===== hdl/vsma_pkg.sv =====
// vsma_pkg: shared widths, register codes, reset values and types
`timescale 1ns / 1ps

package vsma_pkg;

  // field widths
  localparam int DIST_W  = 16;
  localparam int RATE_W  = 8;
  localparam int SUM_W   = 11;
  localparam int AVG_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // default averaging window length
  localparam int WINDOW_DEFAULT = 5;

  // register reset values
  localparam logic [RATE_W-1:0] HEART_LOW_RST      = 8'd30;
  localparam logic [RATE_W-1:0] HEART_HIGH_RST     = 8'd200;
  localparam logic [RATE_W-1:0] BREATH_LOW_RST     = 8'd5;
  localparam logic [RATE_W-1:0] BREATH_HIGH_RST    = 8'd60;
  localparam logic [DIST_W-1:0] DISTANCE_LIMIT_RST = 16'd10000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEART_LOW      = 3'd0,
    REG_HEART_HIGH     = 3'd1,
    REG_BREATH_LOW     = 3'd2,
    REG_BREATH_HIGH    = 3'd3,
    REG_DISTANCE_LIMIT = 3'd4
  } cfg_reg_t;

  // per-sample control into one averaging track
  typedef struct packed {
    logic push;   // write the rate into the ring
    logic clear;  // drop ring, sum and average
  } track_ctl_t;

endpackage

// ===== hdl/vsma_if.sv =====
// vsma_if: sample, result and configuration channel interfaces
`timescale 1ns / 1ps

interface vsma_sample_if;
  import vsma_pkg::*;
  logic              valid;
  logic              ready;
  logic              presence;
  logic [DIST_W-1:0] raw_distance;
  logic [RATE_W-1:0] heart_rate;
  logic [RATE_W-1:0] breath_rate;

  modport source (output valid, presence, raw_distance, heart_rate, breath_rate,
                  input ready);
  modport sink (input valid, presence, raw_distance, heart_rate, breath_rate,
                output ready);
endinterface

interface vsma_result_if;
  import vsma_pkg::*;
  logic              valid;
  logic              ready;
  logic              presence_confirmed;
  logic [DIST_W-1:0] held_distance;
  logic [AVG_W-1:0]  average_heart;
  logic [AVG_W-1:0]  average_breath;

  modport source (output valid, presence_confirmed, held_distance, average_heart,
                  average_breath, input ready);
  modport sink (input valid, presence_confirmed, held_distance, average_heart,
                average_breath, output ready);
endinterface

interface vsma_cfg_if;
  import vsma_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/vital_sign_moving_average.sv =====
// vital_sign_moving_average: gated moving-average filter for radar vital-sign samples
// path: a sample transfer reaches the result through the input register, then the
//   result register (the two register stages)
// throughput: one sample per cycle unless a held result is not taken; the result register frees as it is taken
// reset: synchronous, clears the valid flags of both stages, the rings, sums, slots and held
//   distance to zero and loads the threshold registers with their defaults
`timescale 1ns / 1ps

module vital_sign_moving_average #(
  parameter int WINDOW = vsma_pkg::WINDOW_DEFAULT  // ring length, 1 to 8
) (
  input  logic          clk,
  input  logic          rst,
  vsma_sample_if.sink   sample,
  vsma_result_if.source result,
  vsma_cfg_if.sink      cfg
);
  import vsma_pkg::*;

  // threshold registers
  logic [RATE_W-1:0] heart_low;
  logic [RATE_W-1:0] heart_high;
  logic [RATE_W-1:0] breath_low;
  logic [RATE_W-1:0] breath_high;
  logic [DIST_W-1:0] distance_limit;

  // input register stage
  logic              in_valid;
  logic              in_presence;
  logic [DIST_W-1:0] in_distance;
  logic [RATE_W-1:0] in_heart;
  logic [RATE_W-1:0] in_breath;

  // result register stage
  logic              out_valid;
  logic              out_presence;
  logic [DIST_W-1:0] out_distance;
  logic [AVG_W-1:0]  out_heart;
  logic [AVG_W-1:0]  out_breath;

  // held distance and its update
  logic [DIST_W-1:0] distance_hold;
  logic [DIST_W-1:0] distance_hold_next;

  logic       advance;  // input stage moves into the result register
  track_ctl_t heart_ctl;
  track_ctl_t breath_ctl;
  logic [AVG_W-1:0] heart_avg_next;
  logic [AVG_W-1:0] breath_avg_next;

  // the input stage empties whenever the result register is free or being taken
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;
  // the user must change thresholds only while idle (the block does not enforce it); writes are always taken
  assign cfg.ready    = 1'b1;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      heart_low      <= HEART_LOW_RST;
      heart_high     <= HEART_HIGH_RST;
      breath_low     <= BREATH_LOW_RST;
      breath_high    <= BREATH_HIGH_RST;
      distance_limit <= DISTANCE_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_HEART_LOW:      heart_low      <= cfg.data[RATE_W-1:0];
        REG_HEART_HIGH:     heart_high     <= cfg.data[RATE_W-1:0];
        REG_BREATH_LOW:     breath_low     <= cfg.data[RATE_W-1:0];
        REG_BREATH_HIGH:    breath_high    <= cfg.data[RATE_W-1:0];
        REG_DISTANCE_LIMIT: distance_limit <= cfg.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_presence <= sample.presence;
      in_distance <= sample.raw_distance;
      in_heart    <= sample.heart_rate;
      in_breath   <= sample.breath_rate;
    end
  end

  // gating: readings strictly inside their windows, only while someone is there
  always_comb begin
    heart_ctl.clear  = !in_presence;
    heart_ctl.push   = in_presence && (in_heart > heart_low) && (in_heart < heart_high);
    breath_ctl.clear = !in_presence;
    breath_ctl.push  = in_presence && (in_breath > breath_low) && (in_breath < breath_high);

    if (!in_presence) begin
      distance_hold_next = '0;
    end else if ((in_distance != '0) && (in_distance < distance_limit)) begin
      distance_hold_next = in_distance;
    end else begin
      distance_hold_next = distance_hold;
    end
  end

  vsma_track #(.WINDOW(WINDOW)) u_heart (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .ctl      (heart_ctl),
    .value    (in_heart),
    .avg_next (heart_avg_next)
  );

  vsma_track #(.WINDOW(WINDOW)) u_breath (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .ctl      (breath_ctl),
    .value    (in_breath),
    .avg_next (breath_avg_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_hold <= '0;
    end else if (advance) begin
      distance_hold <= distance_hold_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_presence <= in_presence;
      out_distance <= distance_hold_next;
      out_heart    <= heart_avg_next;
      out_breath   <= breath_avg_next;
    end
  end

  assign result.valid              = out_valid;
  assign result.presence_confirmed = out_presence;
  assign result.held_distance      = out_distance;
  assign result.average_heart      = out_heart;
  assign result.average_breath     = out_breath;

endmodule

// ===== hdl/vsma_track.sv =====
// vsma_track: one rate track, ring of recent readings with running sum and average
`timescale 1ns / 1ps

module vsma_track #(
  parameter int WINDOW = vsma_pkg::WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,   // sample advances this cycle
  input  vsma_pkg::track_ctl_t         ctl,
  input  logic [vsma_pkg::RATE_W-1:0]  value,
  output logic [vsma_pkg::AVG_W-1:0]   avg_next
);
  import vsma_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // floor(x / WINDOW) as multiply by rounded-up reciprocal, exact for SUM_W-bit x
  localparam int DIV_SH = SUM_W + $clog2(WINDOW);
  localparam logic [DIV_SH:0] RECIP = (DIV_SH + 1)'((2 ** DIV_SH + WINDOW - 1) / WINDOW);
  localparam int PROD_W = SUM_W + DIV_SH + 1;

  logic [RATE_W-1:0] ring [WINDOW];
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [PROD_W-1:0] prod;

  always_comb begin
    if (ctl.clear) begin
      sum_next = '0;
    end else if (ctl.push) begin
      sum_next = sum - SUM_W'(ring[slot]) + SUM_W'(value);
    end else begin
      sum_next = sum;
    end
  end

  assign prod     = PROD_W'(sum_next) * PROD_W'(RECIP);
  assign avg_next = prod[DIV_SH +: AVG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) ring[i] <= '0;
      slot <= '0;
      sum  <= '0;
    end else if (step) begin
      sum <= sum_next;
      if (ctl.clear) begin
        // slot position is kept across absence
        for (int i = 0; i < WINDOW; i++) ring[i] <= '0;
      end else if (ctl.push) begin
        ring[slot] <= value;
        slot       <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
      end
    end
  end

endmodule
